// ===== sv/hlbc_pkg.sv =====
package hlbc_pkg;

  // default geometry
  localparam int unsigned DefEntries = 32;
  localparam int unsigned DefBuckets = 13;

  // field widths
  localparam int unsigned DevW    = 8;
  localparam int unsigned BlkW    = 24;
  localparam int unsigned OutIdxW = 5;
  localparam int unsigned BktW    = 6;
  localparam int unsigned CntW    = 8;
  localparam int unsigned TimeW   = 32;

  // hash: bucket = (device * HashMul + block) mod buckets, reciprocal multiply
  localparam int unsigned HashMul  = 100;
  localparam int unsigned HashW    = 25;

  // command codes
  localparam logic [1:0] CmdGet     = 2'd0;
  localparam logic [1:0] CmdRelease = 2'd1;
  localparam logic [1:0] CmdPin     = 2'd2;
  localparam logic [1:0] CmdUnpin   = 2'd3;

  // status codes
  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StNoFree = 2'd1;
  localparam logic [1:0] StZero   = 2'd2;

  localparam logic [CntW-1:0] CountMax = {CntW{1'b1}};

  typedef struct packed {
    logic [1:0]         cmd;
    logic [DevW-1:0]    device;
    logic [BlkW-1:0]    block_number;
    logic [OutIdxW-1:0] entry_index;
    logic [TimeW-1:0]   now;
  } req_t;

  typedef struct packed {
    logic [OutIdxW-1:0] result_entry;
    logic               was_hit;
    logic               needs_read;
    logic [1:0]         status;
  } rsp_t;

  // one stored buffer entry, bucket kept alongside its tag
  typedef struct packed {
    logic [DevW-1:0]  device;
    logic [BlkW-1:0]  block;
    logic [BktW-1:0]  bucket;
    logic [CntW-1:0]  count;
    logic [TimeW-1:0] rtime;
    logic             dvalid;
  } entry_t;

  // saturating count increment
  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] c);
    sat_inc = (c == CountMax) ? c : c + CntW'(1);
  endfunction

endpackage

// ===== sv/hlbc_ram.sv =====
module hlbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/hlbc_hash.sv =====
module hlbc_hash #(
  parameter int unsigned BUCKETS = hlbc_pkg::DefBuckets
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [hlbc_pkg::HashW-1:0]  val_i,
  output logic                        done_o,
  output logic [hlbc_pkg::BktW-1:0]   bucket_o
);

  // quotient = (val * Recip) >> Shift is exact for every val below 2**HashW
  // since the rounding error of Recip times val stays under 2**Shift
  localparam int unsigned Shift = hlbc_pkg::HashW + hlbc_pkg::BktW;
  localparam int unsigned RecW  = Shift + 1;
  localparam int unsigned ProdW = hlbc_pkg::HashW + RecW;
  localparam logic [RecW-1:0] Recip =
      RecW'(((64'd1 << Shift) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
  localparam logic [hlbc_pkg::HashW-1:0] Div = hlbc_pkg::HashW'(BUCKETS);

  logic [hlbc_pkg::HashW-1:0] val_q, quo_q;
  logic [hlbc_pkg::BktW-1:0]  rem_q;
  logic                       val_vld_q, quo_vld_q, done_q;
  logic [ProdW-1:0]           prod;
  logic [hlbc_pkg::HashW-1:0] back;

  // stage one: quotient, stage two: remainder
  assign prod = ProdW'(val_q) * ProdW'(Recip);
  assign back = quo_q * Div;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_vld_q <= 1'b0;
      quo_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      val_vld_q <= start_i;
      quo_vld_q <= val_vld_q;
      if (start_i) begin
        done_q <= 1'b0;
      end else if (quo_vld_q) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= val_i;
    end
    if (val_vld_q) begin
      quo_q <= prod[Shift +: hlbc_pkg::HashW];
    end
    if (quo_vld_q) begin
      rem_q <= hlbc_pkg::BktW'(val_q - back);
    end
  end

  assign done_o   = done_q;
  assign bucket_o = rem_q;

endmodule

// ===== sv/hlbc_scan.sv =====
module hlbc_scan #(
  parameter int unsigned ENTRIES = hlbc_pkg::DefEntries
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clr_i,
  input  logic                       vld_i,
  input  logic [$clog2(ENTRIES)-1:0] idx_i,
  input  hlbc_pkg::entry_t           word_i,
  input  logic [hlbc_pkg::DevW-1:0]  device_i,
  input  logic [hlbc_pkg::BlkW-1:0]  block_i,
  input  logic [hlbc_pkg::BktW-1:0]  home_i,
  output logic                       hit_o,
  output logic [$clog2(ENTRIES)-1:0] hit_idx_o,
  output logic                       free_o,
  output logic [$clog2(ENTRIES)-1:0] free_idx_o
);

  localparam int unsigned IdxW = $clog2(ENTRIES);

  logic                       hit_q, free_q;
  logic [IdxW-1:0]            hit_idx_q, free_idx_q;
  logic                       best_nh_q;
  logic [hlbc_pkg::BktW-1:0]  best_bkt_q;
  logic [hlbc_pkg::TimeW-1:0] best_time_q;

  logic match, is_free, nh, better;

  // candidate order: home bucket, then lowest bucket, then oldest time
  always_comb begin
    match   = (word_i.device == device_i) && (word_i.block == block_i);
    is_free = (word_i.count == '0);
    nh      = (word_i.bucket != home_i);
    if (!free_q) begin
      better = 1'b1;
    end else if (nh != best_nh_q) begin
      better = !nh;
    end else if (word_i.bucket != best_bkt_q) begin
      better = word_i.bucket < best_bkt_q;
    end else begin
      better = word_i.rtime < best_time_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (clr_i) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (vld_i) begin
      if (match) begin
        hit_q <= 1'b1;
      end
      if (is_free && better) begin
        free_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i && !clr_i) begin
      if (match && !hit_q) begin
        hit_idx_q <= idx_i;
      end
      if (is_free && better) begin
        free_idx_q  <= idx_i;
        best_nh_q   <= nh;
        best_bkt_q  <= word_i.bucket;
        best_time_q <= word_i.rtime;
      end
    end
  end

  assign hit_o      = hit_q;
  assign hit_idx_o  = hit_idx_q;
  assign free_o     = free_q;
  assign free_idx_o = free_idx_q;

endmodule

// ===== sv/hashed_lru_buffer_cache_tags.sv =====
// channel | direction | handshake              | word
// --------+-----------+------------------------+------------------------
// in      | input     | in_valid_i / in_ready_o | in_i  (hlbc_pkg::req_t)
// out     | output    | out_valid_o / out_ready_i | out_o (hlbc_pkg::rsp_t)
//
// get runs from the accepted word through the bucket remainder, then one pass
// over the entry memory at one read a cycle, then a read, modify and write of
// the chosen entry. release, pin and unpin skip the remainder and the pass and
// go straight to that read, modify and write. One word is in work at a time; the
// output register lets the next word be taken while a result waits. Reset
// clears per-entry valid bits at once, so no clearing pass is needed.
module hashed_lru_buffer_cache_tags #(
  parameter int unsigned ENTRIES = hlbc_pkg::DefEntries,
  parameter int unsigned BUCKETS = hlbc_pkg::DefBuckets
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  hlbc_pkg::req_t in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hlbc_pkg::rsp_t out_o
);

  localparam int unsigned IdxW  = $clog2(ENTRIES);
  localparam int unsigned WordW = $bits(hlbc_pkg::entry_t);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SHash  = 3'd1;
  localparam logic [2:0] SScan  = 3'd2;
  localparam logic [2:0] SPick  = 3'd3;
  localparam logic [2:0] SFetch = 3'd4;
  localparam logic [2:0] SMod   = 3'd5;

  logic [2:0]         state_q, state_d;
  hlbc_pkg::req_t     req_q;
  logic [IdxW-1:0]    tgt_q, iss_q, rd_idx_q, ra_q;
  logic               iss_done_q, rd_vld_q, hit_q, skip_q;
  logic [ENTRIES-1:0] valid_q;
  logic               out_valid_q;
  hlbc_pkg::rsp_t     out_q;

  logic                      accept, start, hash_done, fire;
  logic [hlbc_pkg::HashW-1:0] hash_val;
  logic [hlbc_pkg::BktW-1:0] home;
  logic                      rd_en, wr_en, we;
  logic [IdxW-1:0]           rd_addr;
  logic [WordW-1:0]          rdata;
  hlbc_pkg::entry_t          word, nword;
  hlbc_pkg::rsp_t            rsp;
  logic                      sc_hit, sc_free;
  logic [IdxW-1:0]           sc_hit_idx, sc_free_idx;

  assign in_ready_o  = (state_q == SIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign start       = accept && (in_i.cmd == hlbc_pkg::CmdGet);
  assign fire        = (state_q == SMod) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // hash input: device * 100 + block
  assign hash_val = hlbc_pkg::HashW'(in_i.device) * hlbc_pkg::HashW'(hlbc_pkg::HashMul)
                  + hlbc_pkg::HashW'(in_i.block_number);

  hlbc_hash #(
    .BUCKETS (BUCKETS)
  ) u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .val_i    (hash_val),
    .done_o   (hash_done),
    .bucket_o (home)
  );

  // memory read port: scan sweep or single fetch
  assign rd_en   = ((state_q == SScan) && !iss_done_q) || (state_q == SFetch);
  assign rd_addr = (state_q == SFetch) ? tgt_q : iss_q;
  assign wr_en   = fire && we;

  hlbc_ram #(
    .WIDTH (WordW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (tgt_q),
    .wdata_i (nword),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // entries never written read as zero
  assign word = valid_q[ra_q] ? hlbc_pkg::entry_t'(rdata) : '0;

  hlbc_scan #(
    .ENTRIES (ENTRIES)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (start),
    .vld_i      (rd_vld_q),
    .idx_i      (rd_idx_q),
    .word_i     (word),
    .device_i   (req_q.device),
    .block_i    (req_q.block_number),
    .home_i     (home),
    .hit_o      (sc_hit),
    .hit_idx_o  (sc_hit_idx),
    .free_o     (sc_free),
    .free_idx_o (sc_free_idx)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (accept) begin
          state_d = (in_i.cmd == hlbc_pkg::CmdGet) ? SHash : SFetch;
        end
      end
      SHash: begin
        if (hash_done) begin
          state_d = SScan;
        end
      end
      SScan: begin
        if (rd_vld_q && (rd_idx_q == LastIdx)) begin
          state_d = SPick;
        end
      end
      SPick:  state_d = SFetch;
      SFetch: state_d = SMod;
      SMod: begin
        if (fire) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // modify the fetched entry and form the result
  always_comb begin
    nword = word;
    we    = 1'b0;
    rsp   = '0;
    rsp.result_entry = req_q.entry_index;
    rsp.status       = hlbc_pkg::StOk;
    case (req_q.cmd) inside
      hlbc_pkg::CmdGet: begin
        if (skip_q) begin
          rsp.result_entry = '0;
          rsp.status       = hlbc_pkg::StNoFree;
        end else begin
          rsp.result_entry = hlbc_pkg::OutIdxW'(tgt_q);
          rsp.was_hit      = hit_q;
          rsp.needs_read   = hit_q ? !word.dvalid : 1'b1;
          if (!hit_q) begin
            nword.device = req_q.device;
            nword.block  = req_q.block_number;
            nword.bucket = home;
          end
          nword.count  = hlbc_pkg::sat_inc(word.count);
          nword.dvalid = 1'b1;
          we = 1'b1;
        end
      end
      hlbc_pkg::CmdPin: begin
        if (!skip_q) begin
          nword.count = hlbc_pkg::sat_inc(word.count);
          we = 1'b1;
        end
      end
      hlbc_pkg::CmdRelease, hlbc_pkg::CmdUnpin: begin
        if (!skip_q) begin
          if (word.count == '0) begin
            rsp.status = hlbc_pkg::StZero;
          end else begin
            nword.count = word.count - hlbc_pkg::CntW'(1);
            if ((req_q.cmd == hlbc_pkg::CmdRelease) &&
                (word.count == hlbc_pkg::CntW'(1))) begin
              nword.rtime = req_q.now;
            end
            we = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      iss_done_q  <= 1'b0;
      rd_vld_q    <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == SScan) && !iss_done_q;
      if (start) begin
        iss_done_q <= 1'b0;
      end else if ((state_q == SScan) && (iss_q == LastIdx)) begin
        iss_done_q <= 1'b1;
      end
      if (wr_en) begin
        valid_q[tgt_q] <= 1'b1;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= in_i;
      tgt_q  <= IdxW'(in_i.entry_index);
      skip_q <= !(32'(in_i.entry_index) < ENTRIES);
      hit_q  <= 1'b0;
      iss_q  <= '0;
    end else if ((state_q == SScan) && !iss_done_q) begin
      iss_q <= iss_q + IdxW'(1);
    end else if (state_q == SPick) begin
      hit_q  <= sc_hit;
      tgt_q  <= sc_hit ? sc_hit_idx : sc_free_idx;
      skip_q <= !sc_hit && !sc_free;
    end
    if (rd_en) begin
      ra_q <= rd_addr;
    end
    rd_idx_q <= iss_q;
    if (fire) begin
      out_q <= rsp;
    end
  end

endmodule

// ===== sim/hashed_lru_buffer_cache_tags_tb.sv =====
module hashed_lru_buffer_cache_tags_tb;
  import hlbc_pkg::*;

  localparam int Entries    = DefEntries;
  localparam int Buckets    = DefBuckets;
  localparam int GetCycles  = Entries + 12;
  localparam int CycleLimit = 400000;
  localparam int TagPool    = 20;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  req_t in_i        = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_o;

  hashed_lru_buffer_cache_tags dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  // clock
  always #4 clk_i = ~clk_i;

  // shadow copy of the tag store
  logic [DevW-1:0]  shadow_dev    [Entries] = '{default: '0};
  logic [BlkW-1:0]  shadow_blk    [Entries] = '{default: '0};
  logic [CntW-1:0]  shadow_cnt    [Entries] = '{default: '0};
  logic [TimeW-1:0] shadow_rtime  [Entries] = '{default: '0};
  logic             shadow_dvalid [Entries] = '{default: 1'b0};

  rsp_t expected_rsp [$];
  int   errors      = 0;
  int   cycle_count = 0;

  // stimulus knobs
  bit               idle_on  = 1'b1;
  int               hold_len = 0;
  int               hold_seq = 0;
  int               hold_seen = 0;
  int               hold_left = 0;
  logic [TimeW-1:0] tick_now = '0;
  logic [DevW-1:0]  pool_dev [TagPool];
  logic [BlkW-1:0]  pool_blk [TagPool];

  function automatic int unsigned home_bucket(input logic [DevW-1:0] d,
                                              input logic [BlkW-1:0] b);
    return (32'(d) * HashMul + 32'(b)) % Buckets;
  endfunction

  // oldest unreferenced entry of a bucket, lowest index on ties, -1 if none
  function automatic int oldest_idle_in(input int unsigned bk);
    int pick;
    int e;
    logic [TimeW-1:0] best;
    pick = -1;
    best = '0;
    for (e = 0; e < Entries; e++) begin
      if (shadow_cnt[e] == '0 && home_bucket(shadow_dev[e], shadow_blk[e]) == bk &&
          (pick < 0 || shadow_rtime[e] < best)) begin
        pick = e;
        best = shadow_rtime[e];
      end
    end
    return pick;
  endfunction

  function automatic void count_up(input int e);
    if (shadow_cnt[e] != CountMax) shadow_cnt[e] = shadow_cnt[e] + 1'b1;
  endfunction

  // expected result of one command, updating the shadow store
  function automatic rsp_t apply_cache_cmd(input req_t w);
    rsp_t r;
    int unsigned home;
    int pick;
    int e;
    int b;
    r = '0;
    if (w.cmd == CmdGet) begin
      home = home_bucket(w.device, w.block_number);
      pick = -1;
      for (e = 0; e < Entries && pick < 0; e++) begin
        if (shadow_dev[e] == w.device && shadow_blk[e] == w.block_number) pick = e;
      end
      if (pick >= 0) begin
        r.was_hit = 1'b1;
        count_up(pick);
      end else begin
        // home bucket first, then the lowest other bucket with a free entry
        pick = oldest_idle_in(home);
        for (b = 0; b < Buckets && pick < 0; b++) begin
          if (b != int'(home)) pick = oldest_idle_in(b);
        end
        if (pick >= 0) begin
          shadow_dev[pick]    = w.device;
          shadow_blk[pick]    = w.block_number;
          shadow_dvalid[pick] = 1'b0;
          count_up(pick);
        end
      end
      if (pick >= 0) begin
        r.result_entry      = OutIdxW'(pick);
        r.needs_read        = ~shadow_dvalid[pick];
        shadow_dvalid[pick] = 1'b1;
      end else begin
        r.status = StNoFree;
      end
    end else begin
      r.result_entry = w.entry_index;
      e = int'(w.entry_index);
      if (e < Entries) begin
        if (w.cmd == CmdPin) begin
          count_up(e);
        end else if (shadow_cnt[e] == '0) begin
          r.status = StZero;
        end else begin
          shadow_cnt[e] = shadow_cnt[e] - 1'b1;
          if (w.cmd == CmdRelease && shadow_cnt[e] == '0) shadow_rtime[e] = w.now;
        end
      end
    end
    return r;
  endfunction

  // stimulus helpers
  function automatic int random_held();
    int held[$];
    int e;
    for (e = 0; e < Entries; e++) begin
      if (shadow_cnt[e] != '0) held.push_back(e);
    end
    if (held.size() == 0) return -1;
    return held[$urandom_range(0, held.size() - 1)];
  endfunction

  function automatic int free_count();
    int n;
    int e;
    n = 0;
    for (e = 0; e < Entries; e++) begin
      if (shadow_cnt[e] == '0) n++;
    end
    return n;
  endfunction

  // mostly rising tick, sometimes any value at all
  function automatic logic [TimeW-1:0] next_now();
    tick_now = tick_now + TimeW'($urandom_range(1, 40));
    if ($urandom_range(0, 11) == 0) return TimeW'($urandom);
    return tick_now;
  endfunction

  function automatic req_t rand_word();
    req_t w;
    w.cmd          = 2'($urandom_range(0, 3));
    w.device       = DevW'($urandom);
    w.block_number = BlkW'($urandom);
    w.entry_index  = OutIdxW'($urandom_range(0, 31));
    w.now          = next_now();
    return w;
  endfunction

  function automatic req_t cmd_word(input logic [1:0] cmd, input logic [DevW-1:0] d,
                                    input logic [BlkW-1:0] b, input logic [OutIdxW-1:0] idx,
                                    input logic [TimeW-1:0] t);
    req_t w;
    w.cmd          = cmd;
    w.device       = d;
    w.block_number = b;
    w.entry_index  = idx;
    w.now          = t;
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got %0h expected %0h", $time, what, got, want);
    errors++;
  endtask

  // send one word, with random idle cycles ahead of it
  task automatic send_word(input req_t w);
    @(negedge clk_i);
    while (idle_on && $urandom_range(0, 99) < 8) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= w;
    do @(posedge clk_i); while (!in_ready_o);
    expected_rsp.push_back(apply_cache_cmd(w));
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
  endtask

  // result checker
  rsp_t want_rsp;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rsp.size() == 0) begin
        report_mismatch("word with nothing pending", 32'(out_o), 32'd0);
      end else begin
        want_rsp = expected_rsp.pop_front();
        if (out_o.result_entry !== want_rsp.result_entry)
          report_mismatch("result_entry", 32'(out_o.result_entry), 32'(want_rsp.result_entry));
        if (out_o.was_hit !== want_rsp.was_hit)
          report_mismatch("was_hit", 32'(out_o.was_hit), 32'(want_rsp.was_hit));
        if (out_o.needs_read !== want_rsp.needs_read)
          report_mismatch("needs_read", 32'(out_o.needs_read), 32'(want_rsp.needs_read));
        if (out_o.status !== want_rsp.status)
          report_mismatch("status", 32'(out_o.status), 32'(want_rsp.status));
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen   <= hold_seq;
      hold_left   <= hold_len;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !(idle_on && $urandom_range(0, 99) < 8);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // extremes, every command and the corner cases of lookup and replacement
  task automatic test_directed_basics();
    // every entry resets to device 0 block 0, so this get hits entry 0 with no data
    send_word(cmd_word(CmdGet, 8'd0, 24'd0, 5'd0, 32'd0));
    send_word(cmd_word(CmdGet, 8'd0, 24'd0, 5'd0, 32'd0));
    send_word(cmd_word(CmdRelease, 8'hFF, 24'hFFFFFF, 5'd0, 32'd5));
    send_word(cmd_word(CmdRelease, 8'd0, 24'd0, 5'd0, 32'hFFFFFFFF));
    // decrement at zero, release and unpin
    send_word(cmd_word(CmdRelease, 8'd0, 24'd0, 5'd0, 32'd7));
    send_word(cmd_word(CmdUnpin, 8'd0, 24'd0, 5'd0, 32'd7));
    // miss reused in the home bucket
    send_word(cmd_word(CmdGet, 8'd0, 24'd13, 5'd0, 32'd0));
    // largest tag, home bucket empty so another bucket gives the entry
    send_word(cmd_word(CmdGet, 8'hFF, 24'hFFFFFF, 5'd0, 32'd0));
    // unpin to zero leaves the release time alone
    send_word(cmd_word(CmdPin, 8'd0, 24'd0, 5'd2, 32'd9));
    send_word(cmd_word(CmdUnpin, 8'd0, 24'd0, 5'd2, 32'd9));
    send_word(cmd_word(CmdUnpin, 8'd0, 24'd0, 5'd2, 32'd9));
    // lowest other bucket, then reuse of a free entry inside the home bucket
    send_word(cmd_word(CmdGet, 8'd0, 24'd1, 5'd0, 32'd0));
    send_word(cmd_word(CmdGet, 8'hFF, 24'hFFFFFF - 24'd13, 5'd0, 32'd0));
    // hit on an unreferenced entry keeps its data
    send_word(cmd_word(CmdRelease, 8'd0, 24'd0, 5'd1, 32'd0));
    send_word(cmd_word(CmdGet, 8'd0, 24'd13, 5'd0, 32'd0));
    send_word(cmd_word(CmdRelease, 8'd0, 24'd0, 5'd1, 32'd100));
    send_word(cmd_word(CmdRelease, 8'd0, 24'd0, 5'd3, 32'd50));
    send_word(cmd_word(CmdGet, 8'd0, 24'd26, 5'd0, 32'd0));
    // highest entry index
    send_word(cmd_word(CmdPin, 8'd0, 24'd0, 5'd31, 32'd0));
    send_word(cmd_word(CmdUnpin, 8'd0, 24'd0, 5'd31, 32'd0));
    send_word(cmd_word(CmdUnpin, 8'd0, 24'd0, 5'd31, 32'd0));
  endtask

  // gets, mostly over a small tag pool, balanced by releases, pins and unpins of held entries
  task automatic test_random_traffic(input int n);
    req_t w;
    int r;
    int e;
    int k;
    for (k = 0; k < n; k++) begin
      w = rand_word();
      r = $urandom_range(0, 99);
      if (r < 45 && free_count() < 6) r = 50 + r % 30;
      if (r < 45) begin
        w.cmd = CmdGet;
        if ($urandom_range(0, 9) < 7) begin
          e = $urandom_range(0, TagPool - 1);
          w.device       = pool_dev[e];
          w.block_number = pool_blk[e];
        end
      end else if (r < 80) begin
        w.cmd = CmdRelease;
        e = random_held();
        if (e >= 0 && $urandom_range(0, 9) != 0) w.entry_index = OutIdxW'(e);
      end else if (r < 90) begin
        w.cmd = CmdPin;
        e = random_held();
        if (e >= 0 && $urandom_range(0, 9) < 7) w.entry_index = OutIdxW'(e);
      end else begin
        w.cmd = CmdUnpin;
        e = random_held();
        if (e >= 0 && $urandom_range(0, 9) != 0) w.entry_index = OutIdxW'(e);
      end
      send_word(w);
    end
  endtask

  task automatic test_no_idle_stretch();
    idle_on = 1'b0;
    test_random_traffic(80);
    idle_on = 1'b1;
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    hold_len = 300;
    hold_seq++;
    test_random_traffic(30);
    wait_drain();
  endtask

  task automatic test_sender_pause();
    int k;
    for (k = 0; k < 3; k++) begin
      test_random_traffic(12);
      wait_drain();
    end
  endtask

  // reference every entry, ask for more, then hand everything back
  task automatic test_pool_exhaustion();
    req_t w;
    int e;
    int k;
    while (free_count() > 0) begin
      w = rand_word();
      e = random_held();
      if (e >= 0 && $urandom_range(0, 4) == 0) begin
        w.cmd         = CmdPin;
        w.entry_index = OutIdxW'(e);
      end else begin
        w.cmd = CmdGet;
      end
      send_word(w);
    end
    for (k = 0; k < 4; k++) begin
      w = rand_word();
      w.cmd = CmdGet;
      if (k == 3) begin
        e = $urandom_range(0, TagPool - 1);
        w.device       = pool_dev[e];
        w.block_number = pool_blk[e];
      end
      send_word(w);
    end
    for (e = 0; e < Entries; e++) begin
      while (shadow_cnt[e] != '0) begin
        w = rand_word();
        w.cmd         = ($urandom_range(0, 3) == 0) ? CmdUnpin : CmdRelease;
        w.entry_index = OutIdxW'(e);
        send_word(w);
      end
    end
  endtask

  // pin one entry past the top of its count
  task automatic test_count_saturation();
    req_t w;
    int e;
    int k;
    e = $urandom_range(0, Entries - 1);
    for (k = 0; k < 262; k++) begin
      w = rand_word();
      w.cmd         = (k == 258 || k == 259) ? CmdUnpin : CmdPin;
      w.entry_index = OutIdxW'(e);
      send_word(w);
    end
  endtask

  initial begin
    int k;
    for (k = 0; k < TagPool; k++) begin
      pool_dev[k] = DevW'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3));
      pool_blk[k] = BlkW'($urandom);
    end
    tick_now = TimeW'($urandom);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_basics();
    wait_drain();
    test_random_traffic(180);
    test_no_idle_stretch();
    test_backpressure();
    test_sender_pause();
    test_pool_exhaustion();
    test_random_traffic(80);
    test_count_saturation();

    wait_drain();
    repeat (GetCycles + 8) @(posedge clk_i);
    if (expected_rsp.size() != 0)
      report_mismatch("words still pending", 32'(expected_rsp.size()), 32'd0);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
